### design/dfe_pkg.sv
`default_nettype none

package dfe_pkg;

    localparam logic [7:0]  DLE_BYTE = 8'h90;
    localparam logic [7:0]  STX_BYTE = 8'h02;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_TOP  = 16'h8000;

    localparam int QUEUE_DEPTH_DEF = 2;

    // One classified word on its way from the front to the back
    typedef struct packed {
        logic [15:0] word;
        logic        hdr;
        logic        last;
        logic [15:0] crc;
    } dfe_entry_t;

    // CRC over one 16-bit word, MSB first; collapses to an XOR matrix
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                             input logic [15:0] word);
        logic [15:0] c;
        logic        carry;
        c = crc_in;
        for (int i = 15; i >= 0; i--)
        begin
            carry = (c & CRC_TOP) != 16'h0000;
            c = {c[14:0], word[i]};
            if (carry)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### design/dfe_front.sv
`default_nettype none

module dfe_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               word_valid,
    output logic                    word_stall,
    input  wire logic [15:0]        word_in,
    output logic                    push,
    output dfe_pkg::dfe_entry_t     push_entry,
    input  wire logic               queue_full
);
    import dfe_pkg::*;

    logic        in_frame_reg;
    logic        in_frame_next;
    logic [7:0]  words_left_reg;
    logic [7:0]  words_left_next;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;

    logic        accept;
    logic [15:0] crc_upd;
    logic        is_last;

    assign word_stall = queue_full;
    assign accept     = word_valid && !queue_full;
    assign push       = accept;

    always_comb
    begin
        crc_upd = crc_feed(in_frame_reg ? crc_reg : 16'h0000, word_in);
        is_last = in_frame_reg ? (words_left_reg == 8'd1) : (word_in[15:8] == 8'd0);

        push_entry.word = word_in;
        push_entry.hdr  = !in_frame_reg;
        push_entry.last = is_last;
        // trailing zero word folded in here
        push_entry.crc  = crc_feed(crc_upd, 16'h0000);

        in_frame_next   = in_frame_reg;
        words_left_next = words_left_reg;
        crc_next        = crc_reg;
        if (accept)
        begin
            if (is_last)
            begin
                in_frame_next   = 1'b0;
                words_left_next = 8'd0;
                crc_next        = 16'h0000;
            end
            else
            begin
                in_frame_next   = 1'b1;
                words_left_next = in_frame_reg ? (words_left_reg - 8'd1) : word_in[15:8];
                crc_next        = crc_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg   <= 1'b0;
            words_left_reg <= 8'd0;
            crc_reg        <= 16'h0000;
        end
        else
        begin
            in_frame_reg   <= in_frame_next;
            words_left_reg <= words_left_next;
            crc_reg        <= crc_next;
        end
    end

endmodule

`default_nettype wire

### design/dfe_queue.sv
`default_nettype none

module dfe_queue #(
    parameter int DEPTH = dfe_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire dfe_pkg::dfe_entry_t push_entry,
    output logic                     full,
    input  wire logic                pop,
    output dfe_pkg::dfe_entry_t      head,
    output logic                     not_empty
);
    import dfe_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    dfe_entry_t    mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign full      = count_reg == CW'(DEPTH);
    assign not_empty = count_reg != '0;
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

### design/dfe_back.sv
`default_nettype none

module dfe_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire dfe_pkg::dfe_entry_t head,
    input  wire logic                not_empty,
    output logic                     pop,
    output logic                     byte_valid,
    input  wire logic                byte_stall,
    output logic [7:0]               byte_out,
    output logic                     frame_end
);
    import dfe_pkg::*;

    typedef enum logic [6:0] {
        PH_START = 7'b0000001,
        PH_DLE   = 7'b0000010,
        PH_STX   = 7'b0000100,
        PH_LO    = 7'b0001000,
        PH_HI    = 7'b0010000,
        PH_CLO   = 7'b0100000,
        PH_CHI   = 7'b1000000
    } phase_t;

    phase_t      phase_reg;
    phase_t      phase_next;
    phase_t      phase_cur;
    phase_t      adv;
    logic        dup_reg;
    logic        dup_next;
    logic        valid_reg;
    logic        valid_next;
    logic [7:0]  byte_reg;
    logic [7:0]  byte_next;
    logic        end_reg;
    logic        end_next;

    logic        load;
    logic [7:0]  src;
    logic        raw;
    logic        ends_item;
    logic        last_byte;
    logic        prefix;

    assign byte_valid = valid_reg;
    assign byte_out   = byte_reg;
    assign frame_end  = end_reg;

    assign load      = not_empty && (!valid_reg || !byte_stall);
    assign phase_cur = (phase_reg == PH_START) ? (head.hdr ? PH_DLE : PH_LO) : phase_reg;

    always_comb
    begin
        src       = DLE_BYTE;
        raw       = 1'b1;
        adv       = PH_START;
        ends_item = 1'b0;
        last_byte = 1'b0;
        case (phase_cur)
            PH_DLE:
            begin
                src = DLE_BYTE;
                adv = PH_STX;
            end
            PH_STX:
            begin
                src = STX_BYTE;
                adv = PH_LO;
            end
            PH_LO:
            begin
                src = head.word[7:0];
                raw = 1'b0;
                adv = PH_HI;
            end
            PH_HI:
            begin
                src       = head.word[15:8];
                raw       = 1'b0;
                adv       = head.last ? PH_CLO : PH_START;
                ends_item = !head.last;
            end
            PH_CLO:
            begin
                src = head.crc[7:0];
                raw = 1'b0;
                adv = PH_CHI;
            end
            PH_CHI:
            begin
                src       = head.crc[15:8];
                raw       = 1'b0;
                adv       = PH_START;
                ends_item = 1'b1;
                last_byte = 1'b1;
            end
            default:
            begin
                adv = PH_START;
            end
        endcase
        // stuffed DLE: first copy goes out, phase holds for the second
        prefix = !raw && (src == DLE_BYTE) && !dup_reg;
    end

    always_comb
    begin
        phase_next = phase_reg;
        dup_next   = dup_reg;
        byte_next  = byte_reg;
        end_next   = end_reg;
        valid_next = valid_reg && byte_stall;
        pop        = 1'b0;
        if (load)
        begin
            valid_next = 1'b1;
            byte_next  = src;
            end_next   = last_byte && !prefix;
            dup_next   = prefix;
            phase_next = prefix ? phase_cur : adv;
            pop        = ends_item && !prefix;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        end_reg  <= end_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            dup_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            dup_reg   <= dup_next;
            valid_reg <= valid_next;
        end
    end

endmodule

`default_nettype wire

### design/dle_frame_encoder_crc16.sv
// Channel   Direction  Handshake                 Payload
// word      in         word_valid / word_stall   word_in[15:0]
// byte      out        byte_valid / byte_stall   byte_out[7:0], frame_end
//
// One output byte per cycle from the back sequencer's output register, unless stalled.
// A data word gives 2 bytes, plus 1 for each 0x90 byte; a header adds 2 (DLE, STX);
// a last word or zero-count header adds 2 to 4 CRC bytes. Words are queued before output.
// The front takes a word every cycle while the queue (QUEUE_DEPTH items) has room.
// Reset clears frame state, queue pointers and output valid.
// A stalled output holds its byte; the front keeps accepting until the queue fills.
`default_nettype none

module dle_frame_encoder_crc16 #(
    parameter int QUEUE_DEPTH = dfe_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        word_valid,
    output logic             word_stall,
    input  wire logic [15:0] word_in,
    output logic             byte_valid,
    input  wire logic        byte_stall,
    output logic [7:0]       byte_out,
    output logic             frame_end
);
    import dfe_pkg::*;

    logic       push;
    dfe_entry_t push_entry;
    logic       full;
    logic       pop;
    dfe_entry_t head;
    logic       not_empty;

    dfe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (word_valid),
        .word_stall (word_stall),
        .word_in    (word_in),
        .push       (push),
        .push_entry (push_entry),
        .queue_full (full)
    );

    dfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .head       (head),
        .not_empty  (not_empty)
    );

    dfe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .not_empty  (not_empty),
        .pop        (pop),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_out   (byte_out),
        .frame_end  (frame_end)
    );

endmodule

`default_nettype wire

### design/dfe_checker.sv
`default_nettype none

module dfe_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        word_valid,
    input wire logic        word_stall,
    input wire logic        byte_valid,
    input wire logic        byte_stall,
    input wire logic [7:0]  byte_out,
    input wire logic        frame_end
);
    import dfe_pkg::*;

    logic word_take;
    logic byte_take;

    assign word_take = word_valid && !word_stall;
    assign byte_take = byte_valid && !byte_stall;

    // stalled output item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_stall |=> byte_valid && $stable(byte_out) && $stable(frame_end))
        else $error("output item changed under stall");

    // an accepted word always produces registered output
    a_word_to_byte: assert property (@(posedge clk) disable iff (!rst_n)
        word_take |-> ##2 byte_valid)
        else $error("accepted word produced no output");

    // a new frame always opens with DLE
    a_frame_open: assert property (@(posedge clk) disable iff (!rst_n)
        byte_take && frame_end |=> !byte_valid || byte_out == DLE_BYTE)
        else $error("frame did not open with DLE");

    // nothing is output straight after reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !byte_valid)
        else $error("output valid after reset");

endmodule

bind dle_frame_encoder_crc16 dfe_checker u_dfe_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .word_valid (word_valid),
    .word_stall (word_stall),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_out   (byte_out),
    .frame_end  (frame_end)
);

`default_nettype wire

### tb/dle_frame_encoder_crc16_tb.sv
`timescale 1ns / 100ps

module dle_frame_encoder_crc16_tb;

    import dfe_pkg::*;

    localparam int IDLE_PCT    = 13;
    localparam int DRAIN_LIMIT = 5000;
    localparam int TAIL_CYCLES = 8;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } serial_byte_t;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        word_valid = 1'b0;
    logic [15:0] word_in    = 16'h0000;
    logic        byte_stall = 1'b0;
    logic        word_stall;
    logic        byte_valid;
    logic [7:0]  byte_out;
    logic        frame_end;

    // predictor state
    logic [15:0] crc_run    = 16'h0000;
    logic [7:0]  words_due  = 8'h00;
    logic        frame_open = 1'b0;

    serial_byte_t expected_bytes[$];

    int fail_count  = 0;
    int words_sent  = 0;
    int bytes_seen  = 0;
    int hold_req    = 0;
    int hold_left   = 0;
    bit src_idle_en = 1'b1;
    bit snk_idle_en = 1'b1;

    dle_frame_encoder_crc16 dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (word_valid),
        .word_stall (word_stall),
        .word_in    (word_in),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_out   (byte_out),
        .frame_end  (frame_end)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= 40)
        begin
            $display("MISMATCH at %0t: %s", $realtime, what);
        end
    endtask

    // {crc, word} modulo the CRC polynomial, i.e. word shifted in MSB first
    function automatic logic [15:0] crc16_shift_word(input logic [15:0] crc,
                                                     input logic [15:0] w);
        logic [31:0] r;
        r = {crc, w};
        for (int k = 31; k >= 16; k--)
        begin
            if (r[k])
            begin
                r[k -: 17] = r[k -: 17] ^ {1'b1, CRC_POLY};
            end
        end
        return r[15:0];
    endfunction

    function automatic void push_stuffed(input logic [7:0] b, input logic last);
        if (b == DLE_BYTE)
        begin
            expected_bytes.push_back('{value: DLE_BYTE, last: 1'b0});
        end
        expected_bytes.push_back('{value: b, last: last});
    endfunction

    function automatic void close_frame();
        logic [15:0] c;
        c = crc16_shift_word(crc_run, 16'h0000);
        push_stuffed(c[7:0], 1'b0);
        push_stuffed(c[15:8], 1'b1);
        crc_run    = 16'h0000;
        words_due  = 8'h00;
        frame_open = 1'b0;
    endfunction

    function automatic void predict_word(input logic [15:0] w);
        if (!frame_open)
        begin
            expected_bytes.push_back('{value: DLE_BYTE, last: 1'b0});
            expected_bytes.push_back('{value: STX_BYTE, last: 1'b0});
            crc_run = crc16_shift_word(16'h0000, w);
            push_stuffed(w[7:0], 1'b0);
            push_stuffed(w[15:8], 1'b0);
            words_due = w[15:8];
            if (words_due == 8'h00)
            begin
                close_frame();
            end
            else
            begin
                frame_open = 1'b1;
            end
        end
        else
        begin
            crc_run = crc16_shift_word(crc_run, w);
            push_stuffed(w[7:0], 1'b0);
            push_stuffed(w[15:8], 1'b0);
            words_due = words_due - 8'h01;
            if (words_due == 8'h00)
            begin
                close_frame();
            end
        end
    endfunction

    // data word for a one-word frame whose CRC low or high byte is DLE
    function automatic logic [15:0] word_for_crc_byte(input logic [15:0] hdr,
                                                      input logic want_high);
        logic [15:0] c;
        for (int d = 0; d < 65536; d++)
        begin
            c = crc16_shift_word(crc16_shift_word(crc16_shift_word(16'h0000, hdr),
                                                  d[15:0]), 16'h0000);
            if ((want_high ? c[15:8] : c[7:0]) == DLE_BYTE)
            begin
                return d[15:0];
            end
        end
        return 16'h0000;
    endfunction

    function automatic logic [15:0] rand_data_word();
        logic [15:0] w;
        w = 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 99) < 15)
        begin
            w[7:0] = DLE_BYTE;
        end
        if ($urandom_range(0, 99) < 15)
        begin
            w[15:8] = DLE_BYTE;
        end
        return w;
    endfunction

    // byte sink: random stalls, or a counted hold-off on request
    always @(posedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0)
        begin
            byte_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            byte_stall <= snk_idle_en && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && byte_valid && !byte_stall)
        begin
            if (expected_bytes.size() == 0)
            begin
                report_mismatch($sformatf("unexpected byte %02h end %b", byte_out,
                                          frame_end));
            end
            else
            begin
                if (byte_out !== expected_bytes[0].value)
                begin
                    report_mismatch($sformatf("byte %0d: byte_out %02h, want %02h",
                                              bytes_seen, byte_out,
                                              expected_bytes[0].value));
                end
                if (frame_end !== expected_bytes[0].last)
                begin
                    report_mismatch($sformatf("byte %0d: frame_end %b, want %b",
                                              bytes_seen, frame_end,
                                              expected_bytes[0].last));
                end
                void'(expected_bytes.pop_front());
            end
            bytes_seen++;
        end
    end

    task automatic send_word(input logic [15:0] w);
        while (src_idle_en && $urandom_range(0, 99) < IDLE_PCT)
        begin
            word_valid <= 1'b0;
            @(posedge clk);
        end
        word_valid <= 1'b1;
        word_in    <= w;
        do
            @(posedge clk);
        while (word_stall !== 1'b0);
        predict_word(w);
        words_sent++;
    endtask

    task automatic send_frame(input logic [7:0] op, input logic [7:0] cnt);
        send_word({cnt, op});
        repeat (cnt)
        begin
            send_word(rand_data_word());
        end
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        word_valid <= 1'b0;
        while (expected_bytes.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        if (expected_bytes.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected bytes never came",
                                      expected_bytes.size()));
            expected_bytes.delete();
        end
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic test_directed();
        logic [15:0] crc_lo_word;
        logic [15:0] crc_hi_word;
        crc_lo_word = word_for_crc_byte(16'h0155, 1'b0);
        crc_hi_word = word_for_crc_byte(16'h0155, 1'b1);
        // zero-count headers, incl. DLE opcode
        send_word(16'h0000);
        send_word(16'h0090);
        send_word(16'h00FF);
        // DLE opcode and a word of two DLE bytes as last word
        send_word(16'h0190);
        send_word(16'h9090);
        send_word(16'h0300);
        send_word(16'h0000);
        send_word(16'hFFFF);
        send_word(16'h9000);
        send_word(16'h0102);
        send_word(16'h0290);
        // CRC bytes that need stuffing
        send_word(16'h0155);
        send_word(crc_lo_word);
        send_word(16'h0155);
        send_word(crc_hi_word);
        wait_drained();
    endtask

    task automatic test_back_to_back();
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        repeat (8)
        begin
            send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 6)));
        end
        wait_drained();
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
    endtask

    task automatic test_output_hold();
        hold_req = 300;
        send_frame(8'($urandom_range(0, 255)), 8'd20);
        wait_drained();
    endtask

    task automatic test_random_frames();
        int first;
        logic [7:0] op;
        logic [7:0] cnt;
        first = words_sent;
        while (words_sent - first < 70)
        begin
            cnt = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(7, 24))
                                              : 8'($urandom_range(0, 6));
            op  = ($urandom_range(0, 9) == 0) ? DLE_BYTE : 8'($urandom_range(0, 255));
            send_frame(op, cnt);
            if ($urandom_range(0, 15) == 0)
            begin
                wait_drained();
            end
        end
        wait_drained();
    endtask

    task automatic test_long_frames();
        send_frame(DLE_BYTE, 8'd40);
        wait_drained();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_back_to_back();
        test_output_hold();
        test_random_frames();
        test_long_frames();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
